/* sv/sdft_pkg.sv */
`timescale 1ns / 1ps

package sdft_pkg;

    localparam int TABLE_ENTRIES = 8;
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    localparam int ID_W   = 32;
    localparam int SEQ_W  = 16;
    localparam int ADDR_W = 64;

    localparam int IN_DATA_W  = ID_W + SEQ_W + ADDR_W;
    localparam int OUT_DATA_W = ID_W + ADDR_W;

    typedef enum logic [1:0] {
        REQ_RECORD  = 2'd0,
        REQ_BY_ADDR = 2'd1,
        REQ_BY_ID   = 2'd2,
        REQ_LATEST  = 2'd3
    } req_type_t;

endpackage

/* sv/sender_duplicate_filter_table_top.sv */
// Each request is registered in the input register; the result register loads from it when the request advances.
// One request per cycle while m_tready does not stall the output; every request yields exactly one result transfer.
// The rate is set by the combinational parallel compare against all table entries.
// Reset (rst_n, asynchronous, active low) clears all entry valid marks and the latest sender.
// Entry address, id and sequence storage is not reset; it is read only once marked valid.
`timescale 1ns / 1ps

module sender_duplicate_filter_table_top
    import sdft_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // node_id, seq_number, node_address
    input  logic [1:0]            s_tuser,   // req_type
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // hit_id, hit_address
    output logic [1:0]            m_tuser    // dup_flag, hit
);

    logic             in_valid_reg;
    req_type_t        in_req_reg;
    logic [ID_W-1:0]  in_id_reg;
    logic [SEQ_W-1:0] in_seq_reg;
    logic [ADDR_W-1:0] in_addr_reg;

    logic [TABLE_ENTRIES-1:0] entry_valid_reg;
    logic [ADDR_W-1:0]        entry_address_reg [TABLE_ENTRIES];
    logic [ID_W-1:0]          entry_id_reg [TABLE_ENTRIES];
    logic [SEQ_W-1:0]         entry_seq_reg [TABLE_ENTRIES];
    logic [ADDR_W-1:0]        latest_address_reg;
    logic                     latest_known_reg;

    logic              out_valid_reg;
    logic              out_dup_reg;
    logic              out_hit_reg;
    logic [ID_W-1:0]   out_id_reg;
    logic [ADDR_W-1:0] out_addr_reg;

    logic              out_dup_next;
    logic              out_hit_next;
    logic [ID_W-1:0]   out_id_next;
    logic [ADDR_W-1:0] out_addr_next;

    logic              advance;
    logic              do_record;
    logic [ADDR_W-1:0] key_addr;
    logic              addr_found;
    logic [IDX_W-1:0]  addr_idx;
    logic              id_found;
    logic [IDX_W-1:0]  id_idx;
    logic [IDX_W-1:0]  free_idx;
    logic [IDX_W-1:0]  wr_idx;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign do_record = advance && (in_req_reg == REQ_RECORD);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_req_reg  <= req_type_t'(s_tuser);
            in_id_reg   <= s_tdata[ID_W-1:0];
            in_seq_reg  <= s_tdata[ID_W+SEQ_W-1:ID_W];
            in_addr_reg <= s_tdata[IN_DATA_W-1:ID_W+SEQ_W];
        end
    end

    // Lowest index wins on multiple matches; loops run from the top down.
    always_comb
    begin
        key_addr   = (in_req_reg == REQ_LATEST) ? latest_address_reg : in_addr_reg;
        addr_found = 1'b0;
        addr_idx   = '0;
        id_found   = 1'b0;
        id_idx     = '0;
        free_idx   = '0;
        for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
        begin
            if (entry_valid_reg[i] && (entry_address_reg[i] == key_addr))
            begin
                addr_found = 1'b1;
                addr_idx   = IDX_W'(i);
            end
            if (entry_valid_reg[i] && (entry_id_reg[i] == in_id_reg))
            begin
                id_found = 1'b1;
                id_idx   = IDX_W'(i);
            end
            if (!entry_valid_reg[i])
            begin
                free_idx = IDX_W'(i);
            end
        end
        wr_idx = addr_found ? addr_idx : free_idx;
    end

    always_comb
    begin
        out_dup_next  = 1'b0;
        out_hit_next  = 1'b0;
        out_id_next   = '0;
        out_addr_next = '0;
        unique case (in_req_reg)
            REQ_RECORD:
            begin
                if (addr_found)
                begin
                    out_dup_next  = (entry_seq_reg[addr_idx] == in_seq_reg);
                    out_hit_next  = 1'b1;
                    out_id_next   = in_id_reg;
                    out_addr_next = in_addr_reg;
                end
            end
            REQ_BY_ADDR:
            begin
                if (addr_found)
                begin
                    out_hit_next  = 1'b1;
                    out_id_next   = entry_id_reg[addr_idx];
                    out_addr_next = entry_address_reg[addr_idx];
                end
            end
            REQ_BY_ID:
            begin
                if (id_found)
                begin
                    out_hit_next  = 1'b1;
                    out_id_next   = entry_id_reg[id_idx];
                    out_addr_next = entry_address_reg[id_idx];
                end
            end
            REQ_LATEST:
            begin
                if (latest_known_reg && addr_found)
                begin
                    out_hit_next  = 1'b1;
                    out_id_next   = entry_id_reg[addr_idx];
                    out_addr_next = entry_address_reg[addr_idx];
                end
            end
            default:
            begin
                out_hit_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg    <= '0;
            latest_known_reg   <= 1'b0;
            latest_address_reg <= '0;
        end
        else if (do_record)
        begin
            entry_valid_reg[wr_idx] <= 1'b1;
            latest_known_reg        <= 1'b1;
            latest_address_reg      <= in_addr_reg;
        end
    end

    // On a hit the stored address already equals the key, so all fields are rewritten.
    always_ff @(posedge clk)
    begin
        if (do_record)
        begin
            entry_address_reg[wr_idx] <= in_addr_reg;
            entry_id_reg[wr_idx]      <= in_id_reg;
            entry_seq_reg[wr_idx]     <= in_seq_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_dup_reg  <= out_dup_next;
            out_hit_reg  <= out_hit_next;
            out_id_reg   <= out_id_next;
            out_addr_reg <= out_addr_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_addr_reg, out_id_reg};
    assign m_tuser  = {out_hit_reg, out_dup_reg};

    a_dup_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (!out_dup_reg || out_hit_reg))
        else $error("Duplicate flagged without a table hit.");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_hit_reg) |-> (out_id_reg == '0 && out_addr_reg == '0))
        else $error("Miss result carries a nonzero id or address.");

    a_record_latest: assert property (@(posedge clk) disable iff (!rst_n)
        do_record |=> (latest_known_reg && latest_address_reg == $past(in_addr_reg)))
        else $error("Record transfer did not update the latest sender.");

    a_valid_grows: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> ($countones(entry_valid_reg) >= $countones($past(entry_valid_reg))))
        else $error("An entry valid mark was lost.");

    a_record_valid: assert property (@(posedge clk) disable iff (!rst_n)
        do_record |=> (entry_valid_reg != '0))
        else $error("Record transfer left the table empty.");

endmodule
